// File: hdl/gasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gasp_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int MAX_SIDE_DEF   = 32;
	localparam int HEAP_DEPTH_DEF = 4096;

	// Fixed widths of the port fields.
	localparam int SIDE_W  = 6;
	localparam int COORD_W = 5;
	localparam int KIND_W  = 2;
	localparam int LEN_W   = 10;

	// Fraction bits of the distance estimate.
	localparam int FRAC_BITS = 8;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// Command codes.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Result codes.
	localparam logic RES_ACK    = 1'b0;
	localparam logic RES_SEARCH = 1'b1;

	// Cell kinds.
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START = 2'd2;
	localparam logic [KIND_W-1:0] KIND_GOAL  = 2'd3;

	// Neighbor directions, visited in this order.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_INIT,
		ST_H_CALC,
		ST_H_WAIT,
		ST_U_BEGIN,
		ST_U_TEST,
		ST_U_CMP,
		ST_POP_CHK,
		ST_POP_TOP,
		ST_POP_LAST,
		ST_D_L,
		ST_D_R,
		ST_D_RC,
		ST_D_SEL,
		ST_GRID_RD,
		ST_GRID_CHK,
		ST_CL_CHK,
		ST_NB_TRY,
		ST_NB_GRID,
		ST_NB_NEXT,
		ST_DONE
	} gasp_state_t;

endpackage

`default_nettype wire

// File: hdl/grid_astar_shortest_path.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// cfg       in         cfg_wr_en             cfg_wr_data (grid side)
// in        in         in_valid / in_stall   command, row, col, cell_kind
// out       out        out_valid / out_stall result_kind, found, path_length
//
// A cell write can follow the previous word back to back while each
// acknowledge is taken. A search first clears the closed marks, one cell per
// cycle, then runs the open list in a heap memory: each push waits for the
// shared square-root unit and then sifts up one heap level at a time, and each
// pop sifts down one level at a time.
// arst_n clears the control state, the side register (to 32) and the stored
// start and goal positions; grid contents are undefined until written.
// A finished word waits in the output register while out_stall is high, and
// the block takes no new input word until that register can be loaded.
module grid_astar_shortest_path #(
	parameter int MAX_SIDE   = gasp_pkg::MAX_SIDE_DEF,
	parameter int HEAP_DEPTH = gasp_pkg::HEAP_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [gasp_pkg::SIDE_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic                         command,
	input  wire logic [gasp_pkg::COORD_W-1:0] row,
	input  wire logic [gasp_pkg::COORD_W-1:0] col,
	input  wire logic [gasp_pkg::KIND_W-1:0]  cell_kind,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic                         result_kind,
	output      logic                         found,
	output      logic [gasp_pkg::LEN_W-1:0]   path_length
);

	import gasp_pkg::*;

	// Cells are addressed as {row, col}, which orders them as row*2**SW+col.
	localparam int SW  = $clog2(MAX_SIDE);
	localparam int PW  = 2 * SW;
	localparam int GW  = PW;
	localparam int KW  = PW + FRAC_BITS + 1;
	localparam int EW  = KW + PW + GW;
	localparam int HIW = $clog2(HEAP_DEPTH);
	localparam int HCW = HIW + 1;
	localparam int RW0 = 2 * SW + 1 + 2 * FRAC_BITS;
	localparam int RW  = RW0 + (RW0 % 2);
	localparam int RTW = RW / 2;
	localparam int XW  = ((SW > COORD_W) ? SW : COORD_W) + 1;
	localparam int CW  = ((SIDE_W > SW + 1) ? SIDE_W : SW + 1) + 1;
	localparam int OW  = (GW > LEN_W) ? GW : LEN_W;

	gasp_state_t state_q, state_d;

	// Control registers.
	logic [SIDE_W-1:0] side_cfg_q;
	logic [PW-1:0]     start_q;
	logic [PW-1:0]     goal_q;
	logic [HCW-1:0]    cnt_q;
	logic              out_valid_q;

	// Search datapath registers.
	logic [SW:0]       side_eff_q;
	logic [PW-1:0]     clr_q;
	logic [PW-1:0]     cur_pos_q;
	logic [GW-1:0]     cur_g_q;
	logic [KW-1:0]     new_key_q;
	logic [PW-1:0]     new_pos_q;
	logic [GW-1:0]     new_g_q;
	logic [EW-1:0]     best_q;
	logic [HIW-1:0]    best_idx_q;
	logic [HIW-1:0]    idx_q;
	logic [1:0]        dir_q;
	logic              nb_mode_q;
	logic              search_found_q;
	logic [LEN_W-1:0]  search_len_q;
	logic              result_kind_q;
	logic              found_q;
	logic [LEN_W-1:0]  path_length_q;

	// Handshake.
	logic out_free;
	logic in_acc;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;

	// Cell write address and range check.
	logic [XW-1:0] row_x;
	logic [XW-1:0] col_x;
	logic          wr_ok;
	logic [PW-1:0] wr_pos;

	assign row_x  = XW'(row);
	assign col_x  = XW'(col);
	assign wr_ok  = (row_x < XW'(MAX_SIDE)) && (col_x < XW'(MAX_SIDE));
	assign wr_pos = {row_x[SW-1:0], col_x[SW-1:0]};

	// Side in use, limited to 1..MAX_SIDE.
	logic [CW-1:0] side_x;
	logic [SW:0]   side_eff;

	assign side_x = CW'(side_cfg_q);

	always_comb begin
		side_eff = side_x[SW:0];
		if (side_x == '0) begin
			side_eff = (SW + 1)'(1);
		end else if (side_x > CW'(MAX_SIDE)) begin
			side_eff = (SW + 1)'(MAX_SIDE);
		end
	end

	logic start_in;
	assign start_in = ({1'b0, start_q[PW-1:SW]} < side_eff) &&
		({1'b0, start_q[SW-1:0]} < side_eff);

	// Neighbor of the current cell in direction dir_q.
	logic [SW-1:0] cur_r;
	logic [SW-1:0] cur_c;
	logic          nb_ok;
	logic [PW-1:0] nb_pos;

	assign cur_r = cur_pos_q[PW-1:SW];
	assign cur_c = cur_pos_q[SW-1:0];

	always_comb begin
		nb_ok  = 1'b0;
		nb_pos = cur_pos_q;
		case (dir_q)
			DIR_UP: begin
				nb_ok  = cur_r != '0;
				nb_pos = {cur_r - SW'(1), cur_c};
			end
			DIR_LEFT: begin
				nb_ok  = cur_c != '0;
				nb_pos = {cur_r, cur_c - SW'(1)};
			end
			DIR_RIGHT: begin
				nb_ok  = ({1'b0, cur_c} + (SW + 1)'(1)) < side_eff_q;
				nb_pos = {cur_r, cur_c + SW'(1)};
			end
			DIR_DOWN: begin
				nb_ok  = ({1'b0, cur_r} + (SW + 1)'(1)) < side_eff_q;
				nb_pos = {cur_r + SW'(1), cur_c};
			end
			default: begin
				nb_ok  = 1'b0;
				nb_pos = cur_pos_q;
			end
		endcase
	end

	// Distance estimate: squared offsets to the goal feed the root unit.
	logic [SW-1:0]   hr, hc, gr, gc, dr, dc;
	logic [2*SW-1:0] dr2, dc2;
	logic [2*SW:0]   sq_sum;
	logic [RW-1:0]   radicand;
	logic            sq_start;
	logic            sq_busy;
	logic [RTW-1:0]  sq_root;
	logic [KW-1:0]   key_calc;

	assign hr       = new_pos_q[PW-1:SW];
	assign hc       = new_pos_q[SW-1:0];
	assign gr       = goal_q[PW-1:SW];
	assign gc       = goal_q[SW-1:0];
	assign dr       = (hr > gr) ? (hr - gr) : (gr - hr);
	assign dc       = (hc > gc) ? (hc - gc) : (gc - hc);
	assign dr2      = {{SW{1'b0}}, dr} * {{SW{1'b0}}, dr};
	assign dc2      = {{SW{1'b0}}, dc} * {{SW{1'b0}}, dc};
	assign sq_sum   = {1'b0, dr2} + {1'b0, dc2};
	assign radicand = RW'({sq_sum, {(2 * FRAC_BITS){1'b0}}});
	assign key_calc = KW'({new_g_q, {FRAC_BITS{1'b0}}}) + KW'(sq_root);

	gasp_isqrt #(
		.W(RW)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(radicand),
		.busy    (sq_busy),
		.root    (sq_root)
	);

	// Memories.
	logic                grid_we;
	logic [PW-1:0]       grid_ra;
	logic [KIND_W-1:0]   grid_rd;
	logic                closed_we;
	logic [PW-1:0]       closed_wa;
	logic                closed_wd;
	logic                closed_rd;
	logic                heap_we;
	logic [HIW-1:0]      heap_wa;
	logic [EW-1:0]       heap_wd;
	logic [HIW-1:0]      heap_ra;
	logic [EW-1:0]       heap_rd;

	gasp_ram #(
		.W    (KIND_W),
		.DEPTH(1 << PW)
	) u_grid_ram (
		.clk  (clk),
		.we   (grid_we),
		.waddr(wr_pos),
		.wdata(cell_kind),
		.raddr(grid_ra),
		.rdata(grid_rd)
	);

	gasp_ram #(
		.W    (1),
		.DEPTH(1 << PW)
	) u_closed_ram (
		.clk  (clk),
		.we   (closed_we),
		.waddr(closed_wa),
		.wdata(closed_wd),
		.raddr(cur_pos_q),
		.rdata(closed_rd)
	);

	gasp_ram #(
		.W    (EW),
		.DEPTH(HEAP_DEPTH)
	) u_heap_ram (
		.clk  (clk),
		.we   (heap_we),
		.waddr(heap_wa),
		.wdata(heap_wd),
		.raddr(heap_ra),
		.rdata(heap_rd)
	);

	// Heap index arithmetic and ordering: entries order by key, then by cell.
	logic [EW-1:0]  new_ent;
	logic [HIW-1:0] parent;
	logic [HCW:0]   child_l;
	logic [HCW:0]   child_r;
	logic [HCW:0]   cnt_x;
	logic [HCW-1:0] cnt_m1;
	logic           l_in;
	logic           r_in;
	logic           heap_full;
	logic           new_before_rd;
	logic           rd_before_best;
	logic           best_before_new;

	assign new_ent         = {new_key_q, new_pos_q, new_g_q};
	assign parent          = (idx_q - HIW'(1)) >> 1;
	assign child_l         = {1'b0, idx_q, 1'b1};
	assign child_r         = child_l + (HCW + 1)'(1);
	assign cnt_x           = {1'b0, cnt_q};
	assign cnt_m1          = cnt_q - HCW'(1);
	assign l_in            = child_l < cnt_x;
	assign r_in            = child_r < cnt_x;
	assign heap_full       = cnt_q >= HCW'(HEAP_DEPTH);
	assign new_before_rd   = new_ent[EW-1:GW] < heap_rd[EW-1:GW];
	assign rd_before_best  = heap_rd[EW-1:GW] < best_q[EW-1:GW];
	assign best_before_new = best_q[EW-1:GW] < new_ent[EW-1:GW];

	// Path length limited to the output width.
	logic [OW-1:0]    g_ext;
	logic [LEN_W-1:0] len_sat;

	assign g_ext   = OW'(cur_g_q);
	assign len_sat = (g_ext > OW'(LEN_MAX)) ? LEN_MAX : g_ext[LEN_W-1:0];

	gasp_state_t push_ret;
	assign push_ret = nb_mode_q ? ST_NB_NEXT : ST_POP_CHK;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (command == CMD_SEARCH)) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = start_in ? ST_H_CALC : ST_DONE;
			end
			ST_H_CALC: begin
				state_d = ST_H_WAIT;
			end
			ST_H_WAIT: begin
				if (!sq_busy) begin
					state_d = ST_U_BEGIN;
				end
			end
			ST_U_BEGIN: begin
				state_d = heap_full ? push_ret : ST_U_TEST;
			end
			ST_U_TEST: begin
				state_d = (idx_q == '0) ? push_ret : ST_U_CMP;
			end
			ST_U_CMP: begin
				state_d = new_before_rd ? ST_U_TEST : push_ret;
			end
			ST_POP_CHK: begin
				state_d = (cnt_q == '0) ? ST_DONE : ST_POP_TOP;
			end
			ST_POP_TOP: begin
				state_d = (cnt_q == HCW'(1)) ? ST_GRID_RD : ST_POP_LAST;
			end
			ST_POP_LAST: begin
				state_d = ST_D_L;
			end
			ST_D_L: begin
				state_d = l_in ? ST_D_R : ST_GRID_RD;
			end
			ST_D_R: begin
				state_d = r_in ? ST_D_RC : ST_D_SEL;
			end
			ST_D_RC: begin
				state_d = ST_D_SEL;
			end
			ST_D_SEL: begin
				state_d = best_before_new ? ST_D_L : ST_GRID_RD;
			end
			ST_GRID_RD: begin
				state_d = ST_GRID_CHK;
			end
			ST_GRID_CHK: begin
				state_d = (grid_rd == KIND_GOAL) ? ST_DONE : ST_CL_CHK;
			end
			ST_CL_CHK: begin
				state_d = closed_rd ? ST_POP_CHK : ST_NB_TRY;
			end
			ST_NB_TRY: begin
				state_d = nb_ok ? ST_NB_GRID : ST_NB_NEXT;
			end
			ST_NB_GRID: begin
				state_d = (grid_rd == KIND_WALL) ? ST_NB_NEXT : ST_H_CALC;
			end
			ST_NB_NEXT: begin
				state_d = (dir_q == DIR_DOWN) ? ST_POP_CHK : ST_NB_TRY;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory and unit controls.
	always_comb begin
		grid_we   = 1'b0;
		grid_ra   = cur_pos_q;
		closed_we = 1'b0;
		closed_wa = cur_pos_q;
		closed_wd = 1'b0;
		heap_we   = 1'b0;
		heap_wa   = idx_q;
		heap_wd   = new_ent;
		heap_ra   = '0;
		sq_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				grid_we = in_acc && (command == CMD_WRITE) && wr_ok;
			end
			ST_CLEAR: begin
				closed_we = 1'b1;
				closed_wa = clr_q;
			end
			ST_H_CALC: begin
				sq_start = 1'b1;
			end
			ST_U_TEST: begin
				heap_we = idx_q == '0;
				heap_ra = parent;
			end
			ST_U_CMP: begin
				heap_we = 1'b1;
				if (new_before_rd) begin
					heap_wd = heap_rd;
				end
			end
			ST_POP_TOP: begin
				heap_ra = cnt_m1[HIW-1:0];
			end
			ST_D_L: begin
				heap_we = !l_in;
				heap_ra = child_l[HIW-1:0];
			end
			ST_D_R: begin
				heap_ra = child_r[HIW-1:0];
			end
			ST_D_SEL: begin
				heap_we = 1'b1;
				if (best_before_new) begin
					heap_wd = best_q;
				end
			end
			ST_CL_CHK: begin
				closed_we = !closed_rd;
				closed_wd = 1'b1;
			end
			ST_NB_TRY: begin
				grid_ra = nb_pos;
			end
			default: begin
				grid_we = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_cfg_q  <= SIDE_W'(32);
			start_q     <= '0;
			goal_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				side_cfg_q <= cfg_wr_data;
			end
			if (grid_we && (cell_kind == KIND_START)) begin
				start_q <= wr_pos;
			end
			if (grid_we && (cell_kind == KIND_GOAL)) begin
				goal_q <= wr_pos;
			end
			if (state_q == ST_CLEAR) begin
				cnt_q <= '0;
			end else if ((state_q == ST_U_BEGIN) && !heap_full) begin
				cnt_q <= cnt_q + HCW'(1);
			end else if (state_q == ST_POP_TOP) begin
				cnt_q <= cnt_m1;
			end
			if ((state_q == ST_IDLE) && in_acc && (command == CMD_WRITE)) begin
				out_valid_q <= 1'b1;
			end else if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search datapath and output word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					result_kind_q <= RES_ACK;
					found_q       <= 1'b0;
					path_length_q <= '0;
					clr_q         <= '0;
					side_eff_q    <= side_eff;
				end
			end
			ST_CLEAR: begin
				clr_q <= clr_q + PW'(1);
			end
			ST_INIT: begin
				new_pos_q      <= start_q;
				new_g_q        <= '0;
				nb_mode_q      <= 1'b0;
				search_found_q <= 1'b0;
				search_len_q   <= '0;
			end
			ST_H_WAIT: begin
				new_key_q <= key_calc;
			end
			ST_U_BEGIN: begin
				idx_q <= cnt_q[HIW-1:0];
			end
			ST_U_CMP: begin
				if (new_before_rd) begin
					idx_q <= parent;
				end
			end
			ST_POP_TOP: begin
				cur_pos_q <= heap_rd[GW+PW-1:GW];
				cur_g_q   <= heap_rd[GW-1:0];
			end
			ST_POP_LAST: begin
				new_key_q <= heap_rd[EW-1:GW+PW];
				new_pos_q <= heap_rd[GW+PW-1:GW];
				new_g_q   <= heap_rd[GW-1:0];
				idx_q     <= '0;
			end
			ST_D_R: begin
				best_q     <= heap_rd;
				best_idx_q <= child_l[HIW-1:0];
			end
			ST_D_RC: begin
				if (rd_before_best) begin
					best_q     <= heap_rd;
					best_idx_q <= child_r[HIW-1:0];
				end
			end
			ST_D_SEL: begin
				if (best_before_new) begin
					idx_q <= best_idx_q;
				end
			end
			ST_GRID_CHK: begin
				if (grid_rd == KIND_GOAL) begin
					search_found_q <= 1'b1;
					search_len_q   <= len_sat;
				end
			end
			ST_CL_CHK: begin
				dir_q <= DIR_UP;
			end
			ST_NB_TRY: begin
				new_pos_q <= nb_pos;
				new_g_q   <= cur_g_q + GW'(1);
				nb_mode_q <= 1'b1;
			end
			ST_NB_NEXT: begin
				dir_q <= dir_q + 2'd1;
			end
			ST_DONE: begin
				if (out_free) begin
					result_kind_q <= RES_SEARCH;
					found_q       <= search_found_q;
					path_length_q <= search_len_q;
				end
			end
			default: begin
				clr_q <= clr_q;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign found       = found_q;
	assign path_length = path_length_q;

`ifndef SYNTHESIS
	// The open list never holds more entries than the heap memory.
	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HCW'(HEAP_DEPTH))
		else $error("heap count beyond heap depth");

	// An acknowledge carries no search outcome, and a miss has no length.
	a_clean_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((result_kind == RES_ACK) || !found)) |-> (path_length == '0))
		else $error("nonzero path length without a found search");

	// A cell write is acknowledged in the next cycle.
	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (command == CMD_WRITE)) |=> (out_valid && (result_kind == RES_ACK)))
		else $error("cell write not acknowledged");

	// The root unit is only started while idle.
	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_busy)
		else $error("root unit restarted while busy");
`endif

endmodule

`default_nettype wire

// File: hdl/gasp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gasp_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/gasp_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-pair integer square root, one result bit per cycle.
module gasp_isqrt #(
	parameter int W = 28
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   radicand,
	output      logic           busy,
	output      logic [W/2-1:0] root
);

	logic [W-1:0] rem_q;
	logic [W-1:0] res_q;
	logic [W-1:0] bit_q;
	logic         busy_q;
	logic [W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[W/2-1:0];

endmodule

`default_nettype wire

// File: tb/tb_grid_astar_shortest_path.sv
`timescale 1ns / 1ps

// Self-checking bench for the grid A* search block. The first part walks a
// short table of words: side changes, cell writes and searches. The results
// of these are typed in where they are obvious, such as an acknowledge, a
// start that is already the goal, a start outside the grid, or a blocked goal.
// After that, random phases change the grid side through its extremes. They
// write random cells and issue searches, and a search-side model of the block
// predicts every result. No cell inside the active grid is ever read before it
// has been written: the bench fills any gaps in the active square before a
// search.
module tb_grid_astar_shortest_path;
	import gasp_pkg::*;

	localparam int SIDE = 32;
	localparam int CELLS = SIDE * SIDE;
	localparam int HEAP_N = 4096;

	// Kinds of rows in the directed table.
	localparam int ROW_CFG  = 0;
	localparam int ROW_WORD = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [SIDE_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_WRITE;
	logic [COORD_W-1:0] row = '0;
	logic [COORD_W-1:0] col = '0;
	logic [KIND_W-1:0] cell_kind = KIND_FREE;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic found;
	logic [LEN_W-1:0] path_length;

	always #6 clk = ~clk;

	grid_astar_shortest_path dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .row(row), .col(col), .cell_kind(cell_kind),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .found(found), .path_length(path_length)
	);

	typedef struct packed {
		logic rkind;
		logic hit;
		logic [LEN_W-1:0] moves;
	} outcome_t;

	outcome_t pending_outcomes[$];

	// The model's copy of the block state.
	logic [KIND_W-1:0] cell_map[CELLS];
	bit cell_known[CELLS];
	bit closed_map[CELLS];
	int unsigned hp_pos[HEAP_N];
	int unsigned hp_g[HEAP_N];
	int unsigned hp_key[HEAP_N];
	int unsigned hp_cnt;
	int unsigned start_at;
	int unsigned goal_at;
	int unsigned side_reg;

	int errors = 0;
	int words_sent = 0;
	int searches = 0;
	int hits = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	function automatic int unsigned root_floor(int unsigned v);
		int unsigned r;
		int unsigned b;
		r = 0;
		b = 32'h4000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit ahead(int unsigned a, int unsigned b);
		if (hp_key[a] != hp_key[b])
			return hp_key[a] < hp_key[b];
		return hp_pos[a] < hp_pos[b];
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		int unsigned t;
		t = hp_pos[a]; hp_pos[a] = hp_pos[b]; hp_pos[b] = t;
		t = hp_g[a]; hp_g[a] = hp_g[b]; hp_g[b] = t;
		t = hp_key[a]; hp_key[a] = hp_key[b]; hp_key[b] = t;
	endfunction

	function automatic void open_push(int unsigned p, int unsigned g);
		int unsigned dr;
		int unsigned dc;
		int unsigned i;
		dr = (p / SIDE > goal_at / SIDE) ? p / SIDE - goal_at / SIDE : goal_at / SIDE - p / SIDE;
		dc = (p % SIDE > goal_at % SIDE) ? p % SIDE - goal_at % SIDE : goal_at % SIDE - p % SIDE;
		if (hp_cnt >= HEAP_N)
			return;
		i = hp_cnt;
		hp_cnt++;
		hp_pos[i] = p;
		hp_g[i] = g;
		hp_key[i] = g * 256 + root_floor((dr * dr + dc * dc) << 16);
		while (i > 0 && ahead(i, (i - 1) / 2)) begin
			swap_slots(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
	endfunction

	function automatic void open_pop(output int unsigned p, output int unsigned g);
		int unsigned i;
		int unsigned l;
		int unsigned m;
		i = 0;
		p = hp_pos[0];
		g = hp_g[0];
		hp_cnt--;
		hp_pos[0] = hp_pos[hp_cnt];
		hp_g[0] = hp_g[hp_cnt];
		hp_key[0] = hp_key[hp_cnt];
		forever begin
			l = 2 * i + 1;
			m = i;
			if (l < hp_cnt && ahead(l, m))
				m = l;
			if (l + 1 < hp_cnt && ahead(l + 1, m))
				m = l + 1;
			if (m == i)
				break;
			swap_slots(i, m);
			i = m;
		end
	endfunction

	function automatic int unsigned active_side();
		if (side_reg < 1)
			return 1;
		if (side_reg > SIDE)
			return SIDE;
		return side_reg;
	endfunction

	// Runs the search on the model grid and returns the outcome word.
	function automatic outcome_t shortest_path();
		outcome_t o;
		int unsigned s;
		int unsigned p;
		int unsigned g;
		int nr;
		int nc;
		int unsigned n;
		int dr[4] = '{-1, 0, 0, 1};
		int dc[4] = '{0, -1, 1, 0};
		o = '{rkind: RES_SEARCH, hit: 1'b0, moves: '0};
		s = active_side();
		foreach (closed_map[i])
			closed_map[i] = 1'b0;
		hp_cnt = 0;
		if (start_at / SIDE < s && start_at % SIDE < s)
			open_push(start_at, 0);
		while (hp_cnt != 0) begin
			open_pop(p, g);
			if (cell_map[p] == KIND_GOAL) begin
				o.hit = 1'b1;
				o.moves = (g > 1023) ? LEN_MAX : g[LEN_W-1:0];
				break;
			end
			if (closed_map[p])
				continue;
			closed_map[p] = 1'b1;
			for (int k = 0; k < 4; k++) begin
				nr = int'(p / SIDE) + dr[k];
				nc = int'(p % SIDE) + dc[k];
				if (nr < 0 || nr >= int'(s) || nc < 0 || nc >= int'(s))
					continue;
				n = nr * SIDE + nc;
				if (cell_map[n] == KIND_WALL)
					continue;
				open_push(n, g + 1);
			end
		end
		hp_cnt = 0;
		return o;
	endfunction

	// Model update for one accepted word.
	function automatic outcome_t apply_word(logic cmd, int unsigned r, int unsigned c,
			logic [KIND_W-1:0] k);
		outcome_t o;
		if (cmd == CMD_SEARCH)
			return shortest_path();
		cell_map[r * SIDE + c] = k;
		cell_known[r * SIDE + c] = 1'b1;
		if (k == KIND_START)
			start_at = r * SIDE + c;
		if (k == KIND_GOAL)
			goal_at = r * SIDE + c;
		o = '{rkind: RES_ACK, hit: 1'b0, moves: '0};
		return o;
	endfunction

	// Presents one word and waits for the block to take it. The valid of the
	// previous word is left high so back-to-back words need no extra edge;
	// whoever comes next decides whether it drops.
	task automatic send_word(logic cmd, int unsigned r, int unsigned c, logic [KIND_W-1:0] k,
			bit typed, outcome_t typed_out);
		outcome_t o;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		row <= r[COORD_W-1:0];
		col <= c[COORD_W-1:0];
		cell_kind <= k;
		do
			@(posedge clk);
		while (in_stall);
		o = apply_word(cmd, r, c, k);
		pending_outcomes.insert(pending_outcomes.size(), typed ? typed_out : o);
		words_sent++;
		if (cmd == CMD_SEARCH)
			searches++;
	endtask

	// Writes the side register once the block has drained.
	task automatic set_side(int unsigned v);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v[SIDE_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		side_reg = v;
	endtask

	// Writes every cell of the active square that has not been written yet,
	// so that a search never meets an undefined cell.
	task automatic fill_square();
		int unsigned s;
		outcome_t none;
		none = '0;
		s = active_side();
		for (int r = 0; r < s; r++)
			for (int c = 0; c < s; c++)
				if (!cell_known[r * SIDE + c])
					send_word(CMD_WRITE, r, c, ($urandom_range(3) == 0) ? KIND_WALL : KIND_FREE,
						1'b0, none);
	endtask

	// Output side: check every word taken and stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: kind %0d found %0d length %0d",
						result_kind, found, path_length);
			end else begin
				outcome_t e;
				e = pending_outcomes.pop_front();
				if (result_kind === RES_SEARCH && found === 1'b1)
					hits++;
				if (result_kind !== e.rkind || found !== e.hit || path_length !== e.moves) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected kind %0d found %0d length %0d, got %0d %0d %0d",
							e.rkind, e.hit, e.moves, result_kind, found, path_length);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	typedef struct {
		int rtype;
		logic cmd;
		int unsigned r;
		int unsigned c;
		logic [KIND_W-1:0] k;
		bit typed;
		outcome_t exp_out;
	} step_row_t;

	localparam outcome_t ACK = '{rkind: RES_ACK, hit: 1'b0, moves: '0};
	localparam outcome_t MISS = '{rkind: RES_SEARCH, hit: 1'b0, moves: '0};
	localparam outcome_t NONE = '0;

	step_row_t plan[] = '{
		'{ROW_CFG, CMD_WRITE, 1, 0, KIND_FREE, 1'b0, NONE},
		'{ROW_WORD, CMD_WRITE, 0, 0, KIND_GOAL, 1'b1, ACK},
		// Start sits on the goal: zero moves.
		'{ROW_WORD, CMD_SEARCH, 31, 31, KIND_GOAL, 1'b1,
			'{rkind: RES_SEARCH, hit: 1'b1, moves: '0}},
		'{ROW_WORD, CMD_WRITE, 0, 0, KIND_FREE, 1'b1, ACK},
		'{ROW_WORD, CMD_SEARCH, 0, 0, KIND_FREE, 1'b1, MISS},
		'{ROW_CFG, CMD_WRITE, 2, 0, KIND_FREE, 1'b0, NONE},
		'{ROW_WORD, CMD_WRITE, 0, 1, KIND_WALL, 1'b1, ACK},
		'{ROW_WORD, CMD_WRITE, 1, 0, KIND_FREE, 1'b1, ACK},
		'{ROW_WORD, CMD_WRITE, 1, 1, KIND_GOAL, 1'b1, ACK},
		// Around the wall: down then right.
		'{ROW_WORD, CMD_SEARCH, 0, 0, KIND_FREE, 1'b1,
			'{rkind: RES_SEARCH, hit: 1'b1, moves: 10'd2}},
		'{ROW_WORD, CMD_WRITE, 0, 0, KIND_START, 1'b1, ACK},
		'{ROW_WORD, CMD_SEARCH, 15, 16, KIND_WALL, 1'b0, NONE},
		// Corners outside the grid in use are stored but never visited.
		'{ROW_WORD, CMD_WRITE, 31, 31, KIND_FREE, 1'b1, ACK},
		'{ROW_WORD, CMD_WRITE, 31, 0, KIND_WALL, 1'b1, ACK},
		'{ROW_WORD, CMD_WRITE, 0, 31, KIND_WALL, 1'b1, ACK},
		// Goal turned into a wall: nothing can end the search.
		'{ROW_WORD, CMD_WRITE, 1, 1, KIND_WALL, 1'b1, ACK},
		'{ROW_WORD, CMD_SEARCH, 0, 0, KIND_FREE, 1'b1, MISS},
		'{ROW_WORD, CMD_WRITE, 1, 1, KIND_GOAL, 1'b1, ACK},
		'{ROW_WORD, CMD_WRITE, 1, 0, KIND_START, 1'b1, ACK},
		'{ROW_WORD, CMD_SEARCH, 0, 0, KIND_FREE, 1'b0, NONE},
		// Start outside the grid.
		'{ROW_WORD, CMD_WRITE, 31, 31, KIND_START, 1'b1, ACK},
		'{ROW_WORD, CMD_SEARCH, 0, 0, KIND_FREE, 1'b1, MISS},
		// A side of zero acts as one; the start cell holds no goal.
		'{ROW_CFG, CMD_WRITE, 0, 0, KIND_FREE, 1'b0, NONE},
		'{ROW_WORD, CMD_WRITE, 0, 0, KIND_START, 1'b1, ACK},
		'{ROW_WORD, CMD_SEARCH, 0, 0, KIND_FREE, 1'b1, MISS}
	};

	int unsigned phase_sides[] = '{1, 2, 5, 0, 8, 63, 3, 12, 4, 32, 6, 2, 7, 1, 5, 3};

	initial begin
		int unsigned s;
		int unsigned r;
		int unsigned c;
		logic [KIND_W-1:0] k;
		int pick;
		foreach (cell_known[i])
			cell_known[i] = 1'b0;
		foreach (cell_map[i])
			cell_map[i] = KIND_FREE;
		hp_cnt = 0;
		start_at = 0;
		goal_at = 0;
		side_reg = 32;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].rtype == ROW_CFG)
				set_side(plan[i].r);
			else
				send_word(plan[i].cmd, plan[i].r, plan[i].c, plan[i].k,
					plan[i].typed, plan[i].exp_out);
		end

		// Random phases: each picks a side and a pattern of idling.
		foreach (phase_sides[p]) begin
			set_side(phase_sides[p]);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 55; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 55; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			s = active_side();
			for (int n = 0; n < 70; n++) begin
				// Large grids search slowly, so they get few searches.
				if ($urandom_range((s >= 12) ? 55 : 11) == 0) begin
					fill_square();
					send_word(CMD_SEARCH, $urandom_range(31), $urandom_range(31),
						KIND_W'($urandom_range(3)), 1'b0, NONE);
				end else begin
					if ($urandom_range(99) < 88) begin
						r = $urandom_range(s - 1);
						c = $urandom_range(s - 1);
					end else begin
						r = $urandom_range(31);
						c = $urandom_range(31);
					end
					pick = $urandom_range(99);
					k = (pick < 55) ? KIND_FREE : (pick < 85) ? KIND_WALL :
						(pick < 92) ? KIND_START : KIND_GOAL;
					send_word(CMD_WRITE, r, c, k, 1'b0, NONE);
				end
			end
			fill_square();
			send_word(CMD_SEARCH, 0, 0, KIND_FREE, 1'b0, NONE);
		end

		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
		repeat (20) @(posedge clk);
		$display("%0d words sent, %0d of them searches (%0d reached a goal).",
			words_sent, searches, hits);
		$display("Grid sides from zero through 63 were visited under four idling patterns.");
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#150ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
hdl/gasp_pkg.sv
hdl/gasp_ram.sv
hdl/gasp_isqrt.sv
hdl/grid_astar_shortest_path.sv
tb/tb_grid_astar_shortest_path.sv
